[hw/rtl/mpq_pkg.sv]
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types, codes and sizes for the max-priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W       = 32;
  localparam int PRI_W         = 16;
  localparam int OCC_W         = 5;
  localparam int STATUS_W      = 2;
  localparam int IN_DATA_W     = 48;
  localparam int OUT_DATA_W    = 40;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                      valid;
    logic [PRI_W-1:0]          pri;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic                      en;
    opcode_t                   op;
    logic [PRI_W-1:0]          pri;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage

[hw/rtl/mpq_cell.sv]
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain: holds an entry, keeps it, takes the new word,
// or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module mpq_cell (
  input  logic          clk,
  input  logic          rst,
  input  mpq_pkg::cmd_t   cmd,
  input  mpq_pkg::entry_t left,
  input  logic          left_stay,
  input  mpq_pkg::entry_t right,
  output mpq_pkg::entry_t cur,
  output logic          stay
);
  import mpq_pkg::*;

  logic                      valid;
  logic [PRI_W-1:0]          pri;
  logic signed [VALUE_W-1:0] value;
  entry_t                    cur_next;

  assign cur  = '{valid: valid, pri: pri, value: value};
  assign stay = valid && (pri > cmd.pri);

  always_comb begin
    cur_next = cur;
    if (cmd.en) begin
      if (cmd.op == OP_REMOVE) begin
        cur_next = right;
      end else if (!stay) begin
        if (left_stay) begin
          cur_next = '{valid: 1'b1, pri: cmd.pri, value: cmd.value};
        end else begin
          cur_next = left;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cur_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    pri   <= cur_next.pri;
    value <= cur_next.value;
  end

endmodule

[hw/rtl/max_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// max_priority_queue_top
// Bounded max-priority queue built as a sorted chain of cells; cell 0 holds
// the highest priority, newest first among equal priorities.
//
//   channel | dir | tdata (low bit up)                      | tuser
//   s_*     | in  | item_value[31:0], item_priority[47:32]  | opcode[0]
//   m_*     | out | removed_value[31:0], status[33:32],     | -
//           |     | occupancy[38:34], zero[39]              |
//
// One word per cycle unless a result stalls in the output register: each
// cell decides in parallel from its own entry, its neighbors and the broadcast word.
// The result appears in the output register the cycle after acceptance.
// s_tready drops only while a result waits in the output register.
// Reset empties the queue at once by clearing the cell valid bits.
// ----------------------------------------------------------------------------
module max_priority_queue_top #(
  parameter int DEPTH = mpq_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mpq_pkg::IN_DATA_W-1:0]  s_tdata,   // item_value, item_priority
  input  logic                           s_tuser,   // opcode
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mpq_pkg::OUT_DATA_W-1:0] m_tdata    // removed_value, status, occupancy
);
  import mpq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic                      accept;
  opcode_t                   op;
  logic                      empty;
  logic                      full;
  logic                      op_ok;
  cmd_t                      cmd;
  logic [CW-1:0]             cnt;
  logic [CW-1:0]             cnt_next;
  logic [CW+OCC_W-1:0]       cnt_ext;
  entry_t                    ent [DEPTH];
  logic [DEPTH-1:0]          stay_v;
  logic [DEPTH-1:0]          valid_vec;
  logic signed [VALUE_W-1:0] out_value;
  status_t                   out_status;
  logic [OCC_W-1:0]          out_occ;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign op       = opcode_t'(s_tuser);
  assign empty    = (cnt == '0);
  assign full     = (cnt == CW'(DEPTH));
  assign op_ok    = (op == OP_INSERT) ? !full : !empty;

  assign cmd = '{en:    accept && op_ok,
                 op:    op,
                 pri:   s_tdata[VALUE_W +: PRI_W],
                 value: s_tdata[VALUE_W-1:0]};

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      entry_t left_e;
      logic   left_s;
      entry_t right_e;
      if (gi == 0) begin : g_head
        assign left_e = '0;
        assign left_s = 1'b1;
      end else begin : g_body
        assign left_e = ent[gi-1];
        assign left_s = stay_v[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_tail
        assign right_e = '0;
      end else begin : g_inner
        assign right_e = ent[gi+1];
      end
      mpq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .cmd       (cmd),
        .left      (left_e),
        .left_stay (left_s),
        .right     (right_e),
        .cur       (ent[gi]),
        .stay      (stay_v[gi])
      );
      assign valid_vec[gi] = ent[gi].valid;
    end
  endgenerate

  always_comb begin
    cnt_next = cnt;
    if (cmd.en) begin
      if (op == OP_INSERT) begin
        cnt_next = cnt + 1'b1;
      end else begin
        cnt_next = cnt - 1'b1;
      end
    end
  end

  assign cnt_ext = {{OCC_W{1'b0}}, cnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_occ <= cnt_ext[OCC_W-1:0];
      if (op == OP_REMOVE) begin
        out_value  <= empty ? '0 : ent[0].value;
        out_status <= empty ? ST_EMPTY : ST_OK;
      end else begin
        out_value  <= '0;
        out_status <= full ? ST_FULL : ST_OK;
      end
    end
  end

  assign m_tdata = {1'b0, out_occ, out_status, out_value};

`ifndef ASSERT_OFF
  a_count_matches : assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(cnt))
    else $error("occupancy count differs from valid cells");

  a_head_when_nonempty : assert property (@(posedge clk) disable iff (rst)
    !empty |-> ent[0].valid)
    else $error("non-empty queue with invalid head cell");

  a_empty_status : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_status == ST_EMPTY) |-> empty)
    else $error("empty status while queue holds entries");

  a_hold_input : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(cnt))
    else $error("queue changed while result stalled");

  generate
    for (gi = 0; gi < DEPTH - 1; gi++) begin : g_chk
      a_sorted : assert property (@(posedge clk) disable iff (rst)
        ent[gi+1].valid |-> (ent[gi].valid && (ent[gi].pri >= ent[gi+1].pri)))
        else $error("chain out of priority order");
    end
  endgenerate
`endif

endmodule

[test/tb_max_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// tb_max_priority_queue_top
// Self-checking bench for the max-priority queue. A queue of pending
// operations feeds a stream driver. A shadow queue, kept in insertion order,
// predicts each result. The monitor checks every output word against the
// oldest prediction. Both sides idle in random bursts until the final stretch.
// ----------------------------------------------------------------------------
module tb_max_priority_queue_top;
  import mpq_pkg::*;

  localparam int QDEPTH   = DEPTH_DEFAULT;
  localparam int N_RANDOM = 1300;
  localparam int QUIET_AT = 150;

  typedef struct {
    opcode_t                   op;
    logic signed [VALUE_W-1:0] value;
    logic [PRI_W-1:0]          pri;
  } mpq_op_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
    logic [OCC_W-1:0]          occ;
  } mpq_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // item_value, item_priority
  logic                  s_tuser = 1'b0; // opcode
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // removed_value, status, occupancy

  mpq_op_t     pending_ops[$];
  mpq_result_t expected_results[$];

  logic signed [VALUE_W-1:0] held_value[QDEPTH];
  logic [PRI_W-1:0]          held_pri[QDEPTH];
  int                        held = 0;

  int err_cnt  = 0;
  int in_gap   = 0;
  int out_stall = 0;
  bit in_taken = 1'b0;

  max_priority_queue_top #(.DEPTH(QDEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic mpq_result_t apply_queue_op(opcode_t op, logic signed [VALUE_W-1:0] v,
                                                 logic [PRI_W-1:0] p);
    mpq_result_t r;
    int          best;
    r.value  = '0;
    r.status = ST_OK;
    if (op == OP_INSERT) begin
      if (held >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        held_value[held] = v;
        held_pri[held]   = p;
        held++;
      end
    end else if (held == 0) begin
      r.status = ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < held; i++) begin
        if (held_pri[i] >= held_pri[best]) best = i;
      end
      r.value = held_value[best];
      for (int i = best; i < held - 1; i++) begin
        held_value[i] = held_value[i + 1];
        held_pri[i]   = held_pri[i + 1];
      end
      held--;
    end
    r.occ = OCC_W'(held);
    return r;
  endfunction

  function automatic logic [PRI_W-1:0] pick_pri();
    case ($urandom_range(0, 3))
      0: return PRI_W'($urandom_range(0, 3));
      1: return $urandom_range(0, 1) ? '1 : '0;
      default: return PRI_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(VALUE_W-1){1'b0}}};
      1: return {1'b0, {(VALUE_W-1){1'b1}}};
      2: return -1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic push_op(opcode_t op, logic signed [VALUE_W-1:0] v, logic [PRI_W-1:0] p);
    mpq_op_t it;
    it.op    = op;
    it.value = v;
    it.pri   = p;
    pending_ops.push_back(it);
  endtask

  // driver
  always @(negedge clk) begin
    mpq_op_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_ops.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (pending_ops.size() > QUIET_AT && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 3);
        s_tvalid <= 1'b0;
      end else begin
        it = pending_ops.pop_front();
        s_tdata  <= {it.pri, it.value};
        s_tuser  <= it.op;
        s_tvalid <= 1'b1;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      m_tready <= 1'b0;
    end else if (pending_ops.size() > QUIET_AT && $urandom_range(0, 5) == 0) begin
      out_stall = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // predict on accepted input words, check accepted output words
  always @(posedge clk) begin
    mpq_result_t exp_r;
    if (!rst && s_tvalid && s_tready) begin
      expected_results.push_back(apply_queue_op(opcode_t'(s_tuser), s_tdata[VALUE_W-1:0],
                                                s_tdata[VALUE_W +: PRI_W]));
      in_taken = 1'b1;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected output word %h", m_tdata);
        err_cnt++;
      end else begin
        exp_r = expected_results.pop_front();
        if (m_tdata[VALUE_W-1:0] !== exp_r.value) begin
          $error("removed_value mismatch: expected %0d, actual %0d",
                 exp_r.value, $signed(m_tdata[VALUE_W-1:0]));
          err_cnt++;
        end
        if (m_tdata[VALUE_W +: STATUS_W] !== exp_r.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 exp_r.status, m_tdata[VALUE_W +: STATUS_W]);
          err_cnt++;
        end
        if (m_tdata[VALUE_W+STATUS_W +: OCC_W] !== exp_r.occ) begin
          $error("occupancy mismatch: expected %0d, actual %0d",
                 exp_r.occ, m_tdata[VALUE_W+STATUS_W +: OCC_W]);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int n;
    int phase_len;
    int ins_pct;

    // empty remove, fill with extremes and ties, refused insert, drain part
    push_op(OP_REMOVE, 32'sd5, 16'hffff);
    push_op(OP_INSERT, {1'b1, 31'd0}, 16'h0000);
    push_op(OP_INSERT, {1'b0, {31{1'b1}}}, 16'hffff);
    push_op(OP_INSERT, -32'sd1, 16'hffff);
    push_op(OP_INSERT, 32'sd0, 16'h0000);
    for (int i = 0; i < 12; i++) begin
      push_op(OP_INSERT, 32'sd100 + i, 16'(i % 3));
    end
    push_op(OP_INSERT, 32'sd77, 16'h8000);
    for (int i = 0; i < 7; i++) begin
      push_op(OP_REMOVE, 32'sd0, 16'h0000);
    end

    n = 0;
    while (n < N_RANDOM) begin
      phase_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0: ins_pct = 15;
        1: ins_pct = 50;
        default: ins_pct = 85;
      endcase
      for (int i = 0; i < phase_len && n < N_RANDOM; i++) begin
        if ($urandom_range(0, 99) < ins_pct) begin
          push_op(OP_INSERT, pick_value(), pick_pri());
        end else begin
          push_op(OP_REMOVE, VALUE_W'($urandom), PRI_W'($urandom));
        end
        n++;
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (pending_ops.size() == 0 && !s_tvalid && expected_results.size() == 0);
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
